/* hw/rtl/ltcp_pkg.sv */
// Shared types and constants for the luma threshold column packer.
// No dependencies; every other file in hw/rtl refers to it by scoped name.
`timescale 1ns / 1ps

package ltcp_pkg;

    // Default data bytes per column packet, before the 3-byte header
    localparam int PACKET_BYTES_DEF = 90;

    // Configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 10;
    localparam logic [CFG_AW-1:0] CFG_HEIGHT = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_THRESH = 1'b1;

    // Height register, held clamped
    localparam int HEIGHT_W = 10;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 10'd232;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 10'd720;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 10'd720;

    // Threshold, held pre-scaled by 1000
    localparam int THR_W    = 9;
    localparam int THR_SC_W = 19;
    localparam logic [9:0]          THR_SCALE  = 10'd1000;
    localparam logic [THR_SC_W-1:0] THR_SC_RST = 19'd128000;

    // Luma weights in thousandths
    localparam int LUMA_W = 18;
    localparam logic [9:0] LUMA_K0 = 10'd299;
    localparam logic [9:0] LUMA_K1 = 10'd587;
    localparam logic [9:0] LUMA_K2 = 10'd114;

    // Column header bytes
    localparam logic [7:0] HDR_CMD  = 8'h67;
    localparam logic [7:0] HDR_ZERO = 8'h00;
    localparam logic [7:0] HDR_LEN  = 8'h5a;
    localparam logic [7:0] PAD_BYTE = 8'h00;

    // Pad count width covers packet sizes up to 255
    localparam int PAD_W = 8;

    // Command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // One command per pixel that produces output
    typedef struct packed {
        logic             hdr;   // column header first
        logic             dat;   // one data byte (full or flushed)
        logic [7:0]       data;
        logic [PAD_W-1:0] pad;   // zero bytes after the data byte
    } t_cmd;

    typedef enum logic [4:0] {
        ST_HDR0 = 5'b00001,
        ST_HDR1 = 5'b00010,
        ST_HDR2 = 5'b00100,
        ST_DATA = 5'b01000,
        ST_PAD  = 5'b10000
    } t_phase;

endpackage

/* hw/rtl/ltcp_front.sv */
// Front end: config registers, luma products, threshold test, bit packing.
// Emits one command per output-producing pixel. Depends on ltcp_pkg.
`timescale 1ns / 1ps

module ltcp_front #(
    parameter int PACKET_BYTES = ltcp_pkg::PACKET_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ltcp_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [ltcp_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_chan0,
    input  logic [7:0]                    i_chan1,
    input  logic [7:0]                    i_chan2,
    input  logic                          i_q_full,
    output logic                          o_push,
    output ltcp_pkg::t_cmd                o_cmd
);

    localparam int LW = ltcp_pkg::LUMA_W;
    localparam int TW = ltcp_pkg::THR_SC_W;
    localparam int HW = ltcp_pkg::HEIGHT_W;
    localparam int PW = ltcp_pkg::PAD_W;
    localparam logic [PW-1:0] PB = PW'(PACKET_BYTES);

    logic [HW-1:0] r_height, n_height;
    logic [TW-1:0] r_thr_sc, n_thr_sc;

    logic          r_s1_valid, n_s1_valid;
    logic [LW-1:0] r_p0, r_p1, r_p2;

    logic [HW-1:0] r_row, n_row;
    logic [2:0]    r_bitpos, n_bitpos;
    logic [7:0]    r_acc, n_acc;

    logic          in_fire, s2_fire;
    logic [LW-1:0] luma;
    logic          black;
    logic [7:0]    acc_new;
    logic [HW-1:0] row_new, row_rnd;
    logic          full, col_end, hdr, dat;
    logic [PW-1:0] data_bytes, pad;

    // Config: height clamped, threshold kept times 1000
    always_comb begin
        n_height = r_height;
        n_thr_sc = r_thr_sc;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                ltcp_pkg::CFG_HEIGHT: begin
                    if (i_cfg_wdata < ltcp_pkg::HEIGHT_MIN) begin
                        n_height = ltcp_pkg::HEIGHT_MIN;
                    end else if (i_cfg_wdata > ltcp_pkg::HEIGHT_MAX) begin
                        n_height = ltcp_pkg::HEIGHT_MAX;
                    end else begin
                        n_height = i_cfg_wdata;
                    end
                end
                ltcp_pkg::CFG_THRESH: begin
                    n_thr_sc = TW'(i_cfg_wdata[ltcp_pkg::THR_W-1:0])
                             * TW'(ltcp_pkg::THR_SCALE);
                end
                default: ;
            endcase
        end
    end

    // Stage 2: sum, compare, pack
    always_comb begin
        luma    = r_p0 + r_p1 + r_p2;
        black   = ({1'b0, luma} < r_thr_sc);
        acc_new = r_acc | (8'(black) << r_bitpos);
        row_new = r_row + HW'(1);
        row_rnd = row_new + HW'(7);
        full    = (r_bitpos == 3'd0);
        col_end = (row_new >= r_height);
        hdr     = (r_row == '0);
        dat     = full || col_end;
        data_bytes = PW'(row_rnd[HW-1:3]);
        pad     = (data_bytes < PB) ? (PB - data_bytes) : '0;

        s2_fire = r_s1_valid && (!(hdr || dat) || !i_q_full);
        o_push  = s2_fire && (hdr || dat);
        o_cmd.hdr  = hdr;
        o_cmd.dat  = dat;
        o_cmd.data = acc_new;
        o_cmd.pad  = col_end ? pad : '0;

        n_row    = r_row;
        n_bitpos = r_bitpos;
        n_acc    = r_acc;
        if (s2_fire) begin
            if (dat) begin
                n_acc    = '0;
                n_bitpos = 3'd7;
            end else begin
                n_acc    = acc_new;
                n_bitpos = r_bitpos - 3'd1;
            end
            n_row = col_end ? '0 : row_new;
        end
    end

    assign o_ready = !r_s1_valid || s2_fire;
    assign in_fire = i_valid && o_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s2_fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height   <= ltcp_pkg::HEIGHT_RST;
            r_thr_sc   <= ltcp_pkg::THR_SC_RST;
            r_s1_valid <= 1'b0;
            r_row      <= '0;
            r_bitpos   <= 3'd7;
            r_acc      <= '0;
        end else begin
            r_height   <= n_height;
            r_thr_sc   <= n_thr_sc;
            r_s1_valid <= n_s1_valid;
            r_row      <= n_row;
            r_bitpos   <= n_bitpos;
            r_acc      <= n_acc;
        end
    end

    // Stage 1: weighted products
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_p0 <= LW'(i_chan0) * LW'(ltcp_pkg::LUMA_K0);
            r_p1 <= LW'(i_chan1) * LW'(ltcp_pkg::LUMA_K1);
            r_p2 <= LW'(i_chan2) * LW'(ltcp_pkg::LUMA_K2);
        end
    end

    // No pending bits may sit in the accumulator at a byte boundary
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bitpos == 3'd7 |-> r_acc == 8'd0)
        else $error("accumulator holds bits at byte boundary");

    // Column end restarts row and bit position
    a_col_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && col_end |=> r_row == '0 && r_bitpos == 3'd7)
        else $error("column end did not restart packing");

endmodule

/* hw/rtl/ltcp_queue.sv */
// Short command queue between the packing front end and the byte sequencer.
// Depends on ltcp_pkg for t_cmd and the depth.
`timescale 1ns / 1ps

module ltcp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ltcp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ltcp_pkg::t_cmd o_head
);

    localparam int AW = ltcp_pkg::Q_AW;
    localparam int CW = ltcp_pkg::Q_AW + 1;
    localparam logic [CW-1:0] DEPTH_N = CW'(ltcp_pkg::Q_DEPTH);

    ltcp_pkg::t_cmd r_mem [ltcp_pkg::Q_DEPTH];
    logic [AW-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]  r_count, n_count;

    assign o_full  = (r_count == DEPTH_N);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp    = i_push ? r_wp + AW'(1) : r_wp;
        n_rp    = i_pop  ? r_rp + AW'(1) : r_rp;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

/* hw/rtl/ltcp_back.sv */
// Back end: expands queued commands into header, data and pad words
// behind a registered output stage. Depends on ltcp_pkg.
`timescale 1ns / 1ps

module ltcp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  ltcp_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last
);

    localparam int PW = ltcp_pkg::PAD_W;

    logic               r_busy, n_busy;
    ltcp_pkg::t_cmd     r_cmd;
    ltcp_pkg::t_phase   r_phase, n_phase, nxt_phase, start_phase;
    logic [PW-1:0]      r_pad, n_pad;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic       out_free, emit, load, fin;
    logic [7:0] cur_byte;

    // Current word and the phase that follows it
    always_comb begin
        cur_byte  = ltcp_pkg::PAD_BYTE;
        nxt_phase = r_phase;
        fin       = 1'b0;
        case (r_phase)
            ltcp_pkg::ST_HDR0: begin
                cur_byte  = ltcp_pkg::HDR_CMD;
                nxt_phase = ltcp_pkg::ST_HDR1;
            end
            ltcp_pkg::ST_HDR1: begin
                cur_byte  = ltcp_pkg::HDR_ZERO;
                nxt_phase = ltcp_pkg::ST_HDR2;
            end
            ltcp_pkg::ST_HDR2: begin
                cur_byte = ltcp_pkg::HDR_LEN;
                if (r_cmd.dat) begin
                    nxt_phase = ltcp_pkg::ST_DATA;
                end else if (r_pad != '0) begin
                    nxt_phase = ltcp_pkg::ST_PAD;
                end else begin
                    fin = 1'b1;
                end
            end
            ltcp_pkg::ST_DATA: begin
                cur_byte = r_cmd.data;
                if (r_pad != '0) begin
                    nxt_phase = ltcp_pkg::ST_PAD;
                end else begin
                    fin = 1'b1;
                end
            end
            ltcp_pkg::ST_PAD: begin
                cur_byte = ltcp_pkg::PAD_BYTE;
                fin      = (r_pad == PW'(1));
            end
            default: begin
                fin = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (i_head.hdr) begin
            start_phase = ltcp_pkg::ST_HDR0;
        end else if (i_head.dat) begin
            start_phase = ltcp_pkg::ST_DATA;
        end else begin
            start_phase = ltcp_pkg::ST_PAD;
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_busy && out_free;
    assign load     = !i_q_empty && (!r_busy || (emit && fin));
    assign o_pop    = load;

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_pad   = r_pad;
        if (load) begin
            n_busy  = 1'b1;
            n_phase = start_phase;
            n_pad   = i_head.pad;
        end else if (emit && fin) begin
            n_busy = 1'b0;
        end else if (emit) begin
            n_phase = nxt_phase;
            if (r_phase == ltcp_pkg::ST_PAD) begin
                n_pad = r_pad - PW'(1);
            end
        end

        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= ltcp_pkg::ST_HDR0;
            r_pad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_pad       <= n_pad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_head;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= fin;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    // Padding phase never runs with an exhausted count
    a_pad_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_phase == ltcp_pkg::ST_PAD |-> r_pad != '0)
        else $error("pad phase with zero count");

endmodule

/* hw/rtl/luma_threshold_column_packer.sv */
// Top level of the luma threshold column packer: stream ports and config port.
// Instantiates ltcp_front, ltcp_queue and ltcp_back; depends on ltcp_pkg.
`timescale 1ns / 1ps

// Turns a column-major stream of three-channel pixels into a thermal printer
// raster stream. A pixel prints black when 299*c0 + 587*c1 + 114*c2 is below
// 1000 times the threshold register; bits pack MSB first. Each column opens
// with 0x67 0x00 0x5a, closes with any partial byte, then zero words up to
// PACKET_BYTES data bytes; tlast marks the final word a pixel causes, and a
// pixel that neither opens a column nor completes a byte yields no word.
// The input takes one pixel per clock while the queue has room and the
// output gives one word per clock while tready is high; a pixel passes the
// stage-1 product registers, is pushed to the command queue and, with the
// back-end sequencer free, is loaded into it, and its first word registered
// on the output. The closing command of a column (one data word and up to
// PACKET_BYTES - 29 pad words) keeps the sequencer busy while the next
// column's header and first three data bytes fill the four-entry command
// queue; input is then held off until the sequencer frees an entry. Config
// writes (index 0 height, clamped to 232..720; index 1 threshold) take
// effect on the next clock and are meant for idle periods only.

module luma_threshold_column_packer #(
    parameter int PACKET_BYTES = ltcp_pkg::PACKET_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_we,
    input  logic [ltcp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [ltcp_pkg::CFG_DW-1:0] i_cfg_wdata,
    // pixel stream in
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [23:0]                 i_s_axis_tdata,  // chan0, chan1, chan2
    // command word stream out
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata,  // out_byte
    output logic                        o_m_axis_tlast
);

    ltcp_pkg::t_cmd q_in_cmd;
    ltcp_pkg::t_cmd q_head;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;

    // Front: pixel classification and bit packing
    ltcp_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_chan0     (i_s_axis_tdata[7:0]),
        .i_chan1     (i_s_axis_tdata[15:8]),
        .i_chan2     (i_s_axis_tdata[23:16]),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in_cmd)
    );

    // Decoupling queue: absorbs pad bursts
    ltcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: header / data / pad word sequencer
    ltcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule
